>>> sv/rdd_pkg.sv
`default_nettype none

package rdd_pkg;

  localparam int unsigned NUM_PROCS = 16;
  localparam int unsigned NUM_RES   = 3;

  // Fixed widths of the row fields: 8 bits per resource, three bytes carried.
  localparam int unsigned FIELD_W   = 24;
  localparam int unsigned FIELD_RES = FIELD_W / 8;
  localparam int unsigned MASK_W    = 16;

  localparam int unsigned IDX_W   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_PROCS + 1);
  // available plus every process's allocation, per resource
  localparam int unsigned WORK_W  = $clog2(255 * (NUM_PROCS + 1) + 1);

  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic REG_AVAIL = 1'b0;

  typedef logic [NUM_RES-1:0][WORK_W-1:0] work_t;

  function automatic logic [7:0] res_byte(input logic [FIELD_W-1:0] vec, input int unsigned j);
    logic [7:0] b;
    b = 8'd0;
    if (j < FIELD_RES) begin
      b = vec[8*j +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> sv/rdd_row_unit.sv
`default_nettype none

// Shared row evaluator: compares one row's request against the work vector
// and forms the work vector with that row's allocation returned.
module rdd_row_unit (
  input  wire rdd_pkg::work_t               work_i,
  input  wire logic [rdd_pkg::FIELD_W-1:0]  alloc_i,
  input  wire logic [rdd_pkg::FIELD_W-1:0]  req_i,
  output rdd_pkg::work_t                    work_o,
  output logic                              fits_o
);

  always_comb begin
    fits_o = 1'b1;
    for (int unsigned j = 0; j < rdd_pkg::NUM_RES; j++) begin
      if (rdd_pkg::WORK_W'(rdd_pkg::res_byte(req_i, j)) > work_i[j]) begin
        fits_o = 1'b0;
      end
      work_o[j] = work_i[j] + rdd_pkg::WORK_W'(rdd_pkg::res_byte(alloc_i, j));
    end
  end

endmodule

`default_nettype wire

>>> sv/resource_deadlock_detector.sv
`default_nettype none

// Loading: one request per cycle, start accepted whenever busy is low.
// Detection after the last row: one row per cycle through the shared row
// evaluator; passes run until one finishes nobody.
// done_o pulses one cycle with the result; it cannot be stalled.
// Reset: asynchronous, clears row count, flags, work vector and available register.
module resource_deadlock_detector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rdd_pkg::FIELD_W-1:0]   alloc_vector_i,
  input  wire logic [rdd_pkg::FIELD_W-1:0]   request_vector_i,
  input  wire logic                          last_row_i,
  output logic                               done_o,
  output logic [rdd_pkg::MASK_W-1:0]         deadlock_mask_o,
  output logic                               deadlock_free_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rdd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rdd_pkg::APB_DW-1:0]    pwdata,
  output logic [rdd_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_e;

  state_e                           state_q;
  logic [rdd_pkg::FIELD_W-1:0]      avail_q;
  logic [rdd_pkg::CNT_W-1:0]        count_q;
  logic [rdd_pkg::IDX_W-1:0]        idx_q;
  logic                             progress_q;
  logic [rdd_pkg::NUM_PROCS-1:0]    fin_q;
  rdd_pkg::work_t                   work_q;

  logic [rdd_pkg::FIELD_W-1:0]      alloc_mem [rdd_pkg::NUM_PROCS];
  logic [rdd_pkg::FIELD_W-1:0]      req_mem   [rdd_pkg::NUM_PROCS];
  logic [rdd_pkg::FIELD_W-1:0]      alloc_rd_q;
  logic [rdd_pkg::FIELD_W-1:0]      req_rd_q;

  logic                             accept;
  logic                             store_row;
  logic [rdd_pkg::IDX_W-1:0]        wr_idx;
  logic [rdd_pkg::IDX_W-1:0]        rd_idx;
  logic [rdd_pkg::IDX_W-1:0]        last_idx;
  rdd_pkg::work_t                   work_sum;
  logic                             fits;
  logic                             take;
  logic [rdd_pkg::MASK_W-1:0]       mask;
  logic                             all_done;
  rdd_pkg::work_t                   work_init;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign store_row = accept && (count_q < rdd_pkg::CNT_W'(rdd_pkg::NUM_PROCS));
  assign wr_idx    = count_q[rdd_pkg::IDX_W-1:0];
  assign last_idx  = rdd_pkg::IDX_W'(count_q - 1'b1);

  // prefetch the row the scan looks at next
  assign rd_idx = ((state_q == ST_SCAN) && (idx_q != last_idx))
                  ? idx_q + 1'b1 : '0;

  // APB: single register, word-decoded
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rdd_pkg::REG_AVAIL)
                  ? rdd_pkg::APB_DW'(avail_q) : '0;

  rdd_row_unit u_row (
    .work_i  (work_q),
    .alloc_i (alloc_rd_q),
    .req_i   (req_rd_q),
    .work_o  (work_sum),
    .fits_o  (fits)
  );

  assign take = !fin_q[idx_q] && fits;

  always_comb begin
    for (int unsigned j = 0; j < rdd_pkg::NUM_RES; j++) begin
      work_init[j] = rdd_pkg::WORK_W'(rdd_pkg::res_byte(avail_q, j));
    end
  end

  always_comb begin
    mask     = '0;
    all_done = 1'b1;
    for (int unsigned i = 0; i < rdd_pkg::NUM_PROCS; i++) begin
      if ((i < count_q) && !fin_q[i]) begin
        all_done = 1'b0;
        if (i < rdd_pkg::MASK_W) begin
          mask[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_row) begin
      alloc_mem[wr_idx] <= alloc_vector_i;
      req_mem[wr_idx]   <= request_vector_i;
    end
    // a row stored at this edge goes straight to the read register
    if (store_row && (wr_idx == rd_idx)) begin
      alloc_rd_q <= alloc_vector_i;
      req_rd_q   <= request_vector_i;
    end else begin
      alloc_rd_q <= alloc_mem[rd_idx];
      req_rd_q   <= req_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      avail_q         <= '0;
      count_q         <= '0;
      idx_q           <= '0;
      progress_q      <= 1'b0;
      fin_q           <= '0;
      work_q          <= '0;
      done_o          <= 1'b0;
      deadlock_mask_o <= '0;
      deadlock_free_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (psel && penable && pwrite && pready && (paddr[2] == rdd_pkg::REG_AVAIL)) begin
        avail_q <= pwdata[rdd_pkg::FIELD_W-1:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (store_row) begin
              count_q        <= count_q + 1'b1;
              fin_q[wr_idx]  <= (alloc_vector_i == '0);
            end
            if (last_row_i) begin
              state_q    <= ST_SCAN;
              idx_q      <= '0;
              progress_q <= 1'b0;
              work_q     <= work_init;
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            work_q       <= work_sum;
            fin_q[idx_q] <= 1'b1;
          end
          if (idx_q == last_idx) begin
            idx_q      <= '0;
            progress_q <= 1'b0;
            // a pass that finished nobody ends detection
            if (!(progress_q || take)) begin
              state_q <= ST_FINISH;
            end
          end else begin
            idx_q      <= idx_q + 1'b1;
            progress_q <= progress_q || take;
          end
        end
        ST_FINISH: begin
          done_o          <= 1'b1;
          deadlock_mask_o <= mask;
          deadlock_free_o <= all_done;
          count_q         <= '0;
          state_q         <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rdd_pkg::CNT_W'(rdd_pkg::NUM_PROCS))
    else $error("row count beyond store depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((count_q != '0) && (idx_q <= last_idx)))
    else $error("scan index outside loaded rows");

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_FINISH) && !busy && (count_q == '0))
    else $error("result strobe without finish step");

  a_flag_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && deadlock_free_o) |-> (deadlock_mask_o == '0))
    else $error("deadlock-free flag set with deadlocked rows");

  a_finish_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> done_o)
    else $error("finish step produced no result");

endmodule

`default_nettype wire

>>> tb/sv/resource_deadlock_detector_tb.sv
`default_nettype none

module resource_deadlock_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PROCS = rdd_pkg::NUM_PROCS;
  localparam int unsigned NUM_RES   = rdd_pkg::NUM_RES;
  localparam int unsigned FIELD_W   = rdd_pkg::FIELD_W;
  localparam int unsigned FIELD_RES = rdd_pkg::FIELD_RES;
  localparam int unsigned MASK_W    = rdd_pkg::MASK_W;
  localparam int unsigned APB_AW    = rdd_pkg::APB_AW;
  localparam int unsigned APB_DW    = rdd_pkg::APB_DW;
  localparam logic        REG_AVAIL = rdd_pkg::REG_AVAIL;

  localparam int unsigned RANDOM_ROWS = 1550;
  localparam logic [APB_AW-1:0] AVAIL_ADDR = APB_AW'(4 * REG_AVAIL);

  typedef struct packed {
    logic [FIELD_W-1:0] alloc;
    logic [FIELD_W-1:0] req;
    logic               last;
  } row_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              ok;
  } verdict_t;

  typedef enum int {
    ROWS_WIDE,    // any 24-bit value
    ROWS_NARROW,  // small per-resource counts, so chains of releases form
    ROWS_MIXED
  } row_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FIELD_W-1:0]  alloc_vector_i = '0;
  logic [FIELD_W-1:0]  request_vector_i = '0;
  logic                last_row_i = 1'b0;
  logic                done_o;
  logic [MASK_W-1:0]   deadlock_mask_o;
  logic                deadlock_free_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  resource_deadlock_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .alloc_vector_i   (alloc_vector_i),
    .request_vector_i (request_vector_i),
    .last_row_i       (last_row_i),
    .done_o           (done_o),
    .deadlock_mask_o  (deadlock_mask_o),
    .deadlock_free_o  (deadlock_free_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the detector state
  logic [FIELD_W-1:0] avail_shadow = '0;
  logic [FIELD_W-1:0] held_rows [NUM_PROCS];
  logic [FIELD_W-1:0] wanted_rows [NUM_PROCS];
  int unsigned        rows_held = 0;

  row_t     row_q [$];
  verdict_t verdict_q [$];

  int unsigned rows_queued = 0;
  int unsigned rows_taken = 0;
  int unsigned verdicts_seen = 0;
  int unsigned deadlocks_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned errors = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // run the release passes over the held rows and queue the verdict
  task automatic judge_batch();
    int unsigned work [NUM_RES];
    bit          freed [NUM_PROCS];
    bit          moved;
    bit          fits;
    verdict_t    v;
    for (int j = 0; j < NUM_RES; j++) begin
      work[j] = (j < FIELD_RES) ? int'(avail_shadow[8*j +: 8]) : 0;
    end
    for (int i = 0; i < NUM_PROCS; i++) begin
      freed[i] = (i < rows_held) && (held_rows[i] == '0);
    end
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (int i = 0; i < rows_held; i++) begin
        if (!freed[i]) begin
          fits = 1'b1;
          for (int j = 0; j < NUM_RES; j++) begin
            if (j < FIELD_RES && int'(wanted_rows[i][8*j +: 8]) > work[j]) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < NUM_RES; j++) begin
              if (j < FIELD_RES) work[j] += int'(held_rows[i][8*j +: 8]);
            end
            freed[i] = 1'b1;
            moved = 1'b1;
          end
        end
      end
    end
    v.mask = '0;
    v.ok = 1'b1;
    for (int i = 0; i < rows_held; i++) begin
      if (!freed[i]) begin
        v.ok = 1'b0;
        if (i < MASK_W) v.mask[i] = 1'b1;
      end
    end
    verdict_q.push_back(v);
    rows_held = 0;
  endtask

  task automatic take_row(input row_t r);
    if (rows_held < NUM_PROCS) begin
      held_rows[rows_held] = r.alloc;
      wanted_rows[rows_held] = r.req;
      rows_held++;
    end
    if (r.last) judge_batch();
  endtask

  // request acceptance and result checking, both sampled at the rising edge
  logic row_taken = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      row_taken <= start && !busy;
      if (start && !busy) begin
        take_row('{alloc: alloc_vector_i, req: request_vector_i, last: last_row_i});
        rows_taken <= rows_taken + 1;
      end
      if (done_o) begin
        verdict_t exp_v;
        verdicts_seen++;
        if (!deadlock_free_o) deadlocks_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending: mask %h ok %b",
                                    deadlock_mask_o, deadlock_free_o));
        end else begin
          exp_v = verdict_q.pop_front();
          if (deadlock_mask_o !== exp_v.mask)
            report_mismatch($sformatf("deadlock_mask %h, want %h", deadlock_mask_o, exp_v.mask));
          if (deadlock_free_o !== exp_v.ok)
            report_mismatch($sformatf("deadlock_free %b, want %b", deadlock_free_o, exp_v.ok));
        end
      end
    end
  end

  // request driver: holds each request until taken, random gaps in between
  int unsigned idle_left = 0;
  bit          burst = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (burst) return 0;
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    row_t r;
    if (rst_ni && (!start || row_taken)) begin
      if ($urandom_range(99) < 2) burst = !burst;
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (row_q.size() > 0) begin
        r = row_q.pop_front();
        alloc_vector_i <= r.alloc;
        request_vector_i <= r.req;
        last_row_i <= r.last;
        start <= 1'b1;
        idle_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic apb_write(input logic [FIELD_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AVAIL_ADDR;
    pwdata <= APB_DW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    avail_shadow = val;
    cfg_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AVAIL_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DW'(avail_shadow))
      report_mismatch($sformatf("available readback %h, want %h", prdata, avail_shadow));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_row(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] r,
                           input logic l);
    row_q.push_back('{alloc: a, req: r, last: l});
    rows_queued++;
  endtask

  function automatic logic [FIELD_W-1:0] narrow_vec(input int unsigned top);
    logic [FIELD_W-1:0] v;
    for (int j = 0; j < FIELD_RES; j++) v[8*j +: 8] = 8'($urandom_range(top));
    return v;
  endfunction

  task automatic queue_batch(input row_mode_e mode);
    int unsigned        n;
    int unsigned        p;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] r;
    row_mode_e          m;
    p = $urandom_range(99);
    if (p < 80) n = $urandom_range(1, 12);
    else if (p < 90) n = NUM_PROCS;
    else n = $urandom_range(NUM_PROCS + 1, NUM_PROCS + 4);  // overflow, extra rows dropped
    for (int i = 0; i < n; i++) begin
      m = (mode == ROWS_MIXED) ? row_mode_e'($urandom_range(1)) : mode;
      if ($urandom_range(99) < 15) a = '0;
      else if (m == ROWS_WIDE) a = FIELD_W'($urandom);
      else a = narrow_vec(6);
      if ($urandom_range(99) < 10) r = '0;
      else if (m == ROWS_WIDE) r = FIELD_W'($urandom);
      else r = narrow_vec(9);
      queue_row(a, r, i == n - 1);
    end
  endtask

  // block idle: every request taken, every result back, busy low
  task automatic wait_drained();
    @(negedge clk_i);
    while (rows_taken != rows_queued || verdict_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    row_mode_e          mode;
    logic [FIELD_W-1:0] av;
    int unsigned        p;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, nothing free
    apb_write('0);
    apb_check();
    @(posedge clk_i);
    queue_row('0, '0, 1'b1);                              // zero allocation finishes at once
    queue_row(24'hFFFFFF, 24'hFFFFFF, 1'b1);              // lone blocked process
    queue_row(24'h000001, 24'h000100, 1'b0);              // two-process cycle
    queue_row(24'h000100, 24'h000001, 1'b1);
    queue_row(24'h000001, 24'h000100, 1'b0);              // needs a second pass
    queue_row(24'h000100, 24'h000000, 1'b1);
    queue_row(24'hFFFFFF, 24'h000000, 1'b1);
    for (int i = 0; i < NUM_PROCS; i++) queue_row(FIELD_W'($urandom), FIELD_W'($urandom), 1'b0);
    queue_row(24'h000000, 24'h000000, 1'b1);              // dropped row still triggers
    wait_drained();

    // directed, everything free
    apb_write(24'hFFFFFF);
    apb_check();
    @(posedge clk_i);
    queue_row(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    queue_row(24'h000000, 24'hFFFFFF, 1'b1);
    wait_drained();

    while (rows_queued < RANDOM_ROWS) begin
      p = $urandom_range(99);
      if (p < 10) av = '0;
      else if (p < 20) av = 24'hFFFFFF;
      else if (p < 40) av = FIELD_W'($urandom);
      else av = narrow_vec(8);
      apb_write(av);
      if ($urandom_range(3) == 0) apb_check();
      @(posedge clk_i);
      p = $urandom_range(99);
      mode = (p < 15) ? ROWS_WIDE : ((p < 70) ? ROWS_NARROW : ROWS_MIXED);
      repeat ($urandom_range(6, 14)) queue_batch(mode);
      wait_drained();
    end

    repeat (300) @(negedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never came", verdict_q.size()));
    $display("Rows sent: %0d, detections checked: %0d (%0d with deadlock), register writes: %0d",
             rows_taken, verdicts_seen, deadlocks_seen, cfg_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d rows taken of %0d", rows_taken, rows_queued);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/rdd_pkg.sv
sv/rdd_row_unit.sv
sv/resource_deadlock_detector.sv
tb/sv/resource_deadlock_detector_tb.sv
